// ----- rtl/crc32e_pkg.sv -----
`default_nettype none

package crc32e_pkg;

    localparam int CRC_W      = 32;
    localparam int DATA_W     = 64;
    localparam int CNT_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 72;   // data_bytes + byte_count, padded to whole bytes
    localparam int M_TDATA_W  = 64;   // remainder + digest
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] SEED_RESET = 32'h0000_0000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLYNOMIAL = 2'd0,
        REG_SEED       = 2'd1,
        REG_INVERT_OUT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              first;
    } crc_item_t;

    typedef struct packed {
        logic [CRC_W-1:0] polynomial;
        logic [CRC_W-1:0] seed;
        logic             invert_out;
    } crc_cfg_t;

    // column i holds the image of remainder bit i
    typedef logic [CRC_W-1:0][CRC_W-1:0] crc_mat_t;

    function automatic logic [CRC_W-1:0] bit_rev32(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++)
        begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // eight lsb-first shift steps of the remainder
    function automatic logic [CRC_W-1:0] crc_shift8(input logic [CRC_W-1:0] v,
                                                    input logic [CRC_W-1:0] rpoly);
        logic [CRC_W-1:0] r;
        r = v;
        for (int b = 0; b < BYTE_W; b++)
        begin
            r = r[0] ? ((r >> 1) ^ rpoly) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] crc_mat_apply(input crc_mat_t m,
                                                       input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < CRC_W; i++)
        begin
            acc = acc ^ (v[i] ? m[i] : '0);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/crc32e_front.sv -----
`default_nettype none

module crc32e_front #(
    parameter int MAX_BYTES = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [crc32e_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                               s_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [crc32e_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [crc32e_pkg::CRC_W-1:0]       cfg_data,
    input  wire logic                               q_full,
    input  wire logic                               build_busy,
    output logic                                    push,
    output crc32e_pkg::crc_item_t                   push_item,
    output crc32e_pkg::crc_cfg_t                    cfg,
    output logic                                    poly_load
);
    import crc32e_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

    logic [CRC_W-1:0] poly_reg;
    logic [CRC_W-1:0] seed_reg;
    logic             invert_reg;
    logic [CNT_W-1:0] raw_count;
    logic             cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg   <= POLY_RESET;
            seed_reg   <= SEED_RESET;
            invert_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POLYNOMIAL: poly_reg   <= cfg_data;
                REG_SEED:       seed_reg   <= cfg_data;
                REG_INVERT_OUT: invert_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign poly_load = cfg_we && (cfg_index == REG_POLYNOMIAL);

    assign cfg.polynomial = poly_reg;
    assign cfg.seed       = seed_reg;
    assign cfg.invert_out = invert_reg;

    // classify: saturate the byte count
    assign raw_count = s_tdata[DATA_W +: CNT_W];

    always_comb
    begin
        push_item.data  = s_tdata[DATA_W-1:0];
        push_item.first = s_tuser;
        push_item.count = (raw_count > MAX_CNT) ? MAX_CNT : raw_count;
    end

    assign s_tready = ~q_full & ~build_busy;
    assign push     = s_tvalid & s_tready;

endmodule

`default_nettype wire

// ----- rtl/crc32e_fifo.sv -----
`default_nettype none

module crc32e_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire crc32e_pkg::crc_item_t  push_item,
    input  wire logic                   pop,
    output crc32e_pkg::crc_item_t       head_item,
    output logic                        not_empty,
    output logic                        full
);
    import crc32e_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    crc_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  fill_reg;
    logic [CNT_QW-1:0]  fill_next;

    assign not_empty = (fill_reg != '0);
    assign full      = (fill_reg == CNT_QW'(QUEUE_DEPTH));
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_QW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/crc32e_mtx.sv -----
`default_nettype none

module crc32e_mtx #(
    parameter int MAX_BYTES = 8,
    parameter int IDX_W     = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [crc32e_pkg::CRC_W-1:0] polynomial,
    input  wire logic               poly_load,
    input  wire logic [IDX_W-1:0]   rd_idx,
    output crc32e_pkg::crc_mat_t    rd_mat,
    output logic                    busy
);
    import crc32e_pkg::*;

    // entry k advances a remainder over k+1 zero bytes
    crc_mat_t           mat_reg [MAX_BYTES];
    crc_mat_t           src_mat;
    crc_mat_t           step_mat;
    logic [IDX_W-1:0]   step_reg;
    logic [IDX_W-1:0]   step_prev;
    logic               busy_reg;
    logic [CRC_W-1:0]   rpoly;

    assign rpoly     = bit_rev32(polynomial);
    assign busy      = busy_reg;
    assign rd_mat    = mat_reg[rd_idx];
    assign step_prev = step_reg - IDX_W'(1);

    always_comb
    begin
        for (int i = 0; i < CRC_W; i++)
        begin
            src_mat[i] = (step_reg == '0) ? (CRC_W'(1) << i) : mat_reg[step_prev][i];
            step_mat[i] = crc_shift8(src_mat[i], rpoly);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (poly_load)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == IDX_W'(MAX_BYTES - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !poly_load)
        begin
            mat_reg[step_reg] <= step_mat;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/crc32e_back.sv -----
`default_nettype none

module crc32e_back #(
    parameter int MAX_BYTES = 8,
    parameter int IDX_W     = 3
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire crc32e_pkg::crc_item_t              head_item,
    input  wire logic                               not_empty,
    output logic                                    pop,
    input  wire crc32e_pkg::crc_cfg_t               cfg,
    output logic [IDX_W-1:0]                        mat_idx,
    input  wire crc32e_pkg::crc_mat_t               mat,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [crc32e_pkg::M_TDATA_W-1:0]        m_tdata
);
    import crc32e_pkg::*;

    localparam int LAST = MAX_BYTES - 1;

    logic               stg_valid_reg [MAX_BYTES];
    crc_item_t          stg_item_reg  [MAX_BYTES];
    logic [CRC_W-1:0]   stg_crc_reg   [MAX_BYTES];

    logic [CRC_W-1:0]   crc_reg;
    logic [CRC_W-1:0]   rem_reg;
    logic               out_valid_reg;
    logic [CRC_W-1:0]   rpoly;
    logic               adv;
    logic [CRC_W-1:0]   crc_start;
    logic [CRC_W-1:0]   crc_next;
    logic [CNT_W-1:0]   cnt_m1;

    assign rpoly = bit_rev32(cfg.polynomial);
    assign adv   = ~out_valid_reg | m_tready;
    assign pop   = adv & not_empty;

    // fold pipeline: stage k folds byte k of the item, starting from zero
    for (genvar k = 0; k < MAX_BYTES; k++)
    begin : g_stage
        crc_item_t          in_item;
        logic               in_valid;
        logic [CRC_W-1:0]   in_crc;
        logic [CRC_W-1:0]   fold_crc;

        if (k == 0)
        begin : g_head
            assign in_item  = head_item;
            assign in_valid = not_empty;
            assign in_crc   = '0;
        end
        else
        begin : g_body
            assign in_item  = stg_item_reg[k-1];
            assign in_valid = stg_valid_reg[k-1];
            assign in_crc   = stg_crc_reg[k-1];
        end

        assign fold_crc = (in_item.count > CNT_W'(k))
                        ? crc_shift8(in_crc ^ {{(CRC_W-BYTE_W){1'b0}},
                                               in_item.data[BYTE_W*k +: BYTE_W]}, rpoly)
                        : in_crc;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                stg_valid_reg[k] <= in_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stg_item_reg[k] <= in_item;
                stg_crc_reg[k]  <= fold_crc;
            end
        end
    end

    // remainder loop: advance the running value over n bytes, add the data part
    assign cnt_m1  = stg_item_reg[LAST].count - CNT_W'(1);
    assign mat_idx = cnt_m1[IDX_W-1:0];

    assign crc_start = stg_item_reg[LAST].first ? cfg.seed : crc_reg;
    assign crc_next  = (stg_item_reg[LAST].count == '0)
                     ? crc_start
                     : (crc_mat_apply(mat, crc_start) ^ stg_crc_reg[LAST]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= stg_valid_reg[LAST];
            if (stg_valid_reg[LAST])
            begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && stg_valid_reg[LAST])
        begin
            rem_reg <= crc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(cfg.invert_out ? ~rem_reg : rem_reg), rem_reg};

endmodule

`default_nettype wire

// ----- rtl/reflected_crc32_engine_unit.sv -----
`default_nettype none

// throughput: one item per cycle when not stalled or rebuilding, set by the remainder
//   loop (a 32x32 matrix step selected by byte count plus the pipelined data fold)
// reset: remainder clears to zero, registers take their defaults, then the
//   shift matrices are rebuilt with s_tready low; a polynomial write starts
//   the same rebuild
module reflected_crc32_engine_unit #(
    parameter int MAX_BYTES = 8     // bytes folded per item, 1 to 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // item input
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [crc32e_pkg::S_TDATA_W-1:0]   s_tdata,  // data_bytes, byte_count, pad
    input  wire logic                               s_tuser,  // first
    // result output
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [crc32e_pkg::M_TDATA_W-1:0]        m_tdata,  // remainder, digest
    // register writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [crc32e_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [crc32e_pkg::CRC_W-1:0]       cfg_data
);
    import crc32e_pkg::*;

    // one index bit minimum so a single-byte build still has a counter
    localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    crc_item_t          push_item;
    crc_item_t          head_item;
    crc_cfg_t           cfg;
    crc_mat_t           mat;
    logic               push;
    logic               pop;
    logic               not_empty;
    logic               q_full;
    logic               poly_load;
    logic               build_busy;
    logic [IDX_W-1:0]   mat_idx;

    // front: takes items, saturates the count, holds the register file
    crc32e_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .build_busy (build_busy),
        .push       (push),
        .push_item  (push_item),
        .cfg        (cfg),
        .poly_load  (poly_load)
    );

    // two-entry queue decouples input from the result side
    crc32e_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_item  (head_item),
        .not_empty  (not_empty),
        .full       (q_full)
    );

    // shift matrices for 1..MAX_BYTES bytes, rebuilt on a polynomial change
    crc32e_mtx #(
        .MAX_BYTES (MAX_BYTES),
        .IDX_W     (IDX_W)
    ) u_mtx (
        .clk        (clk),
        .rst_n      (rst_n),
        .polynomial (cfg.polynomial),
        .poly_load  (poly_load),
        .rd_idx     (mat_idx),
        .rd_mat     (mat),
        .busy       (build_busy)
    );

    // back: byte fold pipeline, remainder loop and output register
    crc32e_back #(
        .MAX_BYTES (MAX_BYTES),
        .IDX_W     (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .not_empty  (not_empty),
        .pop        (pop),
        .cfg        (cfg),
        .mat_idx    (mat_idx),
        .mat        (mat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_reflected_crc32_engine_unit.sv -----
`default_nettype none

module tb_reflected_crc32_engine_unit;

    import crc32e_pkg::*;

    localparam int MAX_BYTES = 8;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;   // no register behind it
    localparam logic [CRC_W-1:0] CASTAGNOLI_POLY = 32'h1EDC_6F41;

    // known check values for the nine-byte message "123456789"
    localparam logic [CRC_W-1:0] CHECK_CRC32  = 32'hCBF4_3926;
    localparam logic [CRC_W-1:0] CHECK_CRC32C = 32'hE306_9283;
    localparam logic [DATA_W-1:0] MSG_HEAD    = 64'h3837_3635_3433_3231;  // "12345678"
    localparam logic [DATA_W-1:0] MSG_TAIL    = 64'h0000_0000_0000_0039;  // "9"

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [DATA_W-1:0]     data;       // message bytes or register value
        logic [CNT_W-1:0]      count;
        logic                  first;
        logic                  pinned;     // expectation typed into the table
        logic [CRC_W-1:0]      remainder;
        logic [CRC_W-1:0]      digest;
    } row_t;

    typedef struct {
        logic [CRC_W-1:0] remainder;
        logic [CRC_W-1:0] digest;
    } crc_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CRC_W-1:0]      cfg_data = '0;

    // typed expectation travels with the item on the bus
    logic                  pin_valid = 1'b0;
    logic [CRC_W-1:0]      pin_remainder = '0;
    logic [CRC_W-1:0]      pin_digest = '0;

    // own copy of the engine registers and running remainder
    logic [CRC_W-1:0]      model_poly = POLY_RESET;
    logic [CRC_W-1:0]      model_seed = SEED_RESET;
    logic                  model_invert = 1'b0;
    logic [CRC_W-1:0]      model_remainder = '0;

    crc_result_t           pending_results[$];   // digests still owed by the engine
    int                    mismatch_count = 0;
    int                    idle_pct = 0;         // sender idle chance per cycle
    int                    stall_pct = 0;        // receiver stall chance per cycle
    row_t                  plan[$];

    reflected_crc32_engine_unit #(
        .MAX_BYTES (MAX_BYTES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // generous ceiling on the whole run
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // bit-reversed generator for lsb-first folding
    function automatic logic [CRC_W-1:0] mirror_word(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++)
        begin
            r[CRC_W-1-i] = v[i];
        end
        return r;
    endfunction

    // fold the low nbytes of the message into the remainder, first byte first
    function automatic logic [CRC_W-1:0] fold_message(input logic [CRC_W-1:0] start,
                                                      input logic [DATA_W-1:0] msg,
                                                      input int nbytes,
                                                      input logic [CRC_W-1:0] rpoly);
        logic [CRC_W-1:0] acc;
        acc = start;
        for (int i = 0; i < nbytes; i++)
        begin
            acc = acc ^ {{(CRC_W-BYTE_W){1'b0}}, msg[BYTE_W*i +: BYTE_W]};
            for (int b = 0; b < BYTE_W; b++)
            begin
                acc = acc[0] ? ((acc >> 1) ^ rpoly) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what, input logic [CRC_W-1:0] got,
                                   input logic [CRC_W-1:0] want);
        $display("mismatch at %0t: %s got %08h expected %08h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // predictor and checker, all on the rising edge in one process so that
    // an acceptance and a result in the same cycle are ordered by the code
    always @(posedge clk)
    begin : watch
        logic [DATA_W-1:0] in_data;
        logic [CNT_W-1:0]  in_count;
        int                nbytes;
        logic [CRC_W-1:0]  start;
        crc_result_t       want;
        if (rst_n)
        begin
            // register write, out-of-range index ignored
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POLYNOMIAL: model_poly = cfg_data;
                    REG_SEED:       model_seed = cfg_data;
                    REG_INVERT_OUT: model_invert = cfg_data[0];
                    default:        ;
                endcase
            end
            // accepted item: predict its result
            if (s_tvalid && s_tready)
            begin
                in_data  = s_tdata[DATA_W-1:0];
                in_count = s_tdata[DATA_W +: CNT_W];
                // counts above the unroll width saturate, zero folds nothing
                nbytes = (in_count > MAX_BYTES) ? MAX_BYTES : int'(in_count);
                start = s_tuser ? model_seed : model_remainder;
                model_remainder = fold_message(start, in_data, nbytes, mirror_word(model_poly));
                if (pin_valid)
                begin
                    want.remainder = pin_remainder;
                    want.digest    = pin_digest;
                end
                else
                begin
                    want.remainder = model_remainder;
                    want.digest    = model_invert ? ~model_remainder : model_remainder;
                end
                pending_results.push_back(want);
            end
            // accepted result: compare with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result, remainder", m_tdata[CRC_W-1:0], '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[CRC_W-1:0] !== want.remainder)
                        report_mismatch("remainder", m_tdata[CRC_W-1:0], want.remainder);
                    if (m_tdata[CRC_W +: CRC_W] !== want.digest)
                        report_mismatch("digest", m_tdata[CRC_W +: CRC_W], want.digest);
                end
            end
        end
    end

    // present one item from the falling edge, hold it until taken;
    // returns on the falling edge after acceptance with tvalid still high
    task automatic send_item(input logic [DATA_W-1:0] msg, input logic [CNT_W-1:0] count,
                             input logic first, input logic pinned,
                             input logic [CRC_W-1:0] rem, input logic [CRC_W-1:0] dig);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= {{(S_TDATA_W-DATA_W-CNT_W){1'b0}}, count, msg};
        s_tuser       <= first;
        pin_valid     <= pinned;
        pin_remainder <= rem;
        pin_digest    <= dig;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // drop the item stream, let the engine drain, then write one register
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CRC_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (MAX_BYTES + 1) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic row_t item_row(input logic [DATA_W-1:0] msg,
                                      input logic [CNT_W-1:0] count, input logic first,
                                      input logic pinned = 1'b0,
                                      input logic [CRC_W-1:0] rem = '0,
                                      input logic [CRC_W-1:0] dig = '0);
        row_t r;
        r.kind = ROW_ITEM;
        r.index = REG_POLYNOMIAL;
        r.data = msg;
        r.count = count;
        r.first = first;
        r.pinned = pinned;
        r.remainder = rem;
        r.digest = dig;
        return r;
    endfunction

    function automatic row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CRC_W-1:0] value);
        row_t r;
        r = item_row({{(DATA_W-CRC_W){1'b0}}, value}, '0, 1'b0);
        r.kind = ROW_WRITE;
        r.index = idx;
        return r;
    endfunction

    // a fresh register setting, extremes weighted in
    task automatic pick_setting();
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] seed_val;
        case ($urandom_range(0, 4))
            0:       poly = POLY_RESET;
            1:       poly = CASTAGNOLI_POLY;
            2:       poly = '0;
            3:       poly = '1;
            default: poly = $urandom;
        endcase
        case ($urandom_range(0, 2))
            0:       seed_val = '0;
            1:       seed_val = '1;
            default: seed_val = $urandom;
        endcase
        write_register(REG_POLYNOMIAL, poly);
        write_register(REG_SEED, seed_val);
        write_register(REG_INVERT_OUT, CRC_W'($urandom_range(0, 1)));
    endtask

    // messages of several items with random content; a few start without
    // the first flag and some carry odd byte counts
    task automatic send_messages(input int n_items);
        int left;
        int msg_len;
        logic [CNT_W-1:0] count;
        left = n_items;
        while (left > 0)
        begin
            msg_len = $urandom_range(1, 12);
            for (int k = 0; k < msg_len && left > 0; k++)
            begin
                if ($urandom_range(0, 9) < 8)
                    count = CNT_W'($urandom_range(1, MAX_BYTES));
                else
                    count = CNT_W'($urandom_range(0, 15));
                send_item({$urandom, $urandom}, count,
                          (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                          1'b0, '0, '0);
                left--;
            end
        end
    endtask

    initial
    begin
        // directed part: zeros out of reset, count extremes, ignored upper
        // bytes, the standard check strings under both polynomials, the
        // unmapped register index and the all-zero / all-one generators
        plan.push_back(item_row('0, 4'd0, 1'b0, 1'b1, '0, '0));
        plan.push_back(item_row('1, 4'd0, 1'b1, 1'b1, '0, '0));
        plan.push_back(item_row('0, 4'd8, 1'b0, 1'b1, '0, '0));
        plan.push_back(item_row('1, 4'd8, 1'b0));
        plan.push_back(item_row(64'hA5C3_0F96_5A3C_F069, 4'd15, 1'b0));
        plan.push_back(item_row(64'h0123_4567_89AB_CDEF, 4'd9, 1'b0));
        plan.push_back(item_row(64'hFFFF_FFFF_FFFF_FF00, 4'd1, 1'b0));
        plan.push_back(item_row(64'h8000_0000_0000_0001, 4'd3, 1'b0));
        plan.push_back(write_row(REG_SEED, '1));
        plan.push_back(write_row(REG_INVERT_OUT, 32'd1));
        plan.push_back(item_row(MSG_HEAD, 4'd8, 1'b1));
        plan.push_back(item_row(MSG_TAIL, 4'd1, 1'b0, 1'b1, ~CHECK_CRC32, CHECK_CRC32));
        plan.push_back(write_row(REG_POLYNOMIAL, CASTAGNOLI_POLY));
        plan.push_back(item_row(MSG_HEAD, 4'd8, 1'b1));
        plan.push_back(item_row(MSG_TAIL, 4'd1, 1'b0, 1'b1, ~CHECK_CRC32C, CHECK_CRC32C));
        plan.push_back(write_row(REG_UNMAPPED, '1));
        plan.push_back(item_row(64'hDEAD_BEEF_CAFE_F00D, 4'd6, 1'b1));
        plan.push_back(write_row(REG_POLYNOMIAL, '0));
        plan.push_back(item_row(64'h1122_3344_5566_7788, 4'd4, 1'b1));
        plan.push_back(item_row('1, 4'd8, 1'b0));
        plan.push_back(write_row(REG_POLYNOMIAL, '1));
        plan.push_back(write_row(REG_SEED, '0));
        plan.push_back(write_row(REG_INVERT_OUT, '0));
        plan.push_back(item_row(64'h7E7E_7E7E_7E7E_7E7E, 4'd7, 1'b1));
        plan.push_back(item_row(64'h0000_0000_0000_FFFF, 4'd2, 1'b0));
        plan.push_back(item_row(64'h0F0F_0F0F_0F0F_0F0F, 4'd0, 1'b1));
        plan.push_back(item_row(64'hF0F0_F0F0_F0F0_F0F0, 4'd8, 1'b0));
        plan.push_back(write_row(REG_POLYNOMIAL, POLY_RESET));

        // reset once, released on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
                write_register(plan[i].index, plan[i].data[CRC_W-1:0]);
            else
                send_item(plan[i].data, plan[i].count, plan[i].first, plan[i].pinned,
                          plan[i].remainder, plan[i].digest);
        end

        // random part: four idling profiles, two settings in each
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 81; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            for (int half = 0; half < 2; half++)
            begin
                pick_setting();
                send_messages(50);
            end
        end

        // drain and allow for stray results after the last one
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (MAX_BYTES + 4) @(negedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/crc32e_pkg.sv
rtl/crc32e_front.sv
rtl/crc32e_fifo.sv
rtl/crc32e_mtx.sv
rtl/crc32e_back.sv
rtl/reflected_crc32_engine_unit.sv
tb/sv/tb_reflected_crc32_engine_unit.sv
